// File: hw/rtl/nested_comment_integer_lexer_top_defines.svh
// Assertion macros shared by the lexer RTL
`ifndef NESTED_COMMENT_INTEGER_LEXER_TOP_DEFINES_SVH
`define NESTED_COMMENT_INTEGER_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NCIL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define NCIL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ncil_pkg.sv
// Shared types and constants for the nested comment integer lexer
`default_nettype none
package ncil_pkg;

   // result value width
   localparam int VALUE_W = 38;

   // lexer modes
   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_TOKEN,
      MODE_LINE,
      MODE_BLOCK
   } mode_type;

   // result kinds
   localparam logic [1:0] KIND_INT = 2'd0;
   localparam logic [1:0] KIND_ERR = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   // character codes
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

endpackage
`default_nettype wire

// File: hw/rtl/ncil_if.sv
// Valid/ready channel interfaces for lexer input bytes and result tokens
`default_nettype none
interface ncil_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface ncil_rsp_if;
   import ncil_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                token_kind;
   logic signed [VALUE_W-1:0] token_value;
   logic                      error_flag;

   modport source (output valid, output token_kind, output token_value,
                   output error_flag, input ready);
   modport sink   (input valid, input token_kind, input token_value,
                   input error_flag, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nested_comment_integer_lexer_top.sv
// Top level of the streaming nested comment integer lexer
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------
//   req_chan | in        | data_byte[7:0], stream_end
//   rsp_chan | out       | token_kind[1:0], token_value[37:0], error_flag
//
// One byte is taken every cycle unless the result stalls; zero or one
// result per byte. A byte passes through an input register, then the
// lexer update into the result register. A stalled result holds both
// stages; req_chan.ready then drops once the input register is full.
// Reset is synchronous and returns the lexer to idle with no error.
`default_nettype none
`include "nested_comment_integer_lexer_top_defines.svh"
module nested_comment_integer_lexer_top #(
   parameter int MAX_TOKEN_CHARS = 50,
   parameter int MAX_INT_CHARS   = 11,
   parameter int MAX_NESTING     = 255
) (
   input  wire          clock,
   input  wire          reset,
   ncil_req_if.sink     req_chan,
   ncil_rsp_if.source   rsp_chan
);
   import ncil_pkg::*;

   // bits needed for the largest MAX_INT_CHARS-digit magnitude
   function automatic int acc_width(int n);
      longint unsigned p;
      int              w;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      p = p - 1;
      w = 0;
      while (p != 0) begin
         w++;
         p = p >> 1;
      end
      return w;
   endfunction

   localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
   localparam int DEP_W = $clog2(MAX_NESTING + 1);
   localparam int ACC_W = acc_width(MAX_INT_CHARS);
   localparam int NEG_W = (ACC_W + 1 > VALUE_W) ? ACC_W + 1 : VALUE_W;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [ACC_W-1:0] acc;
      logic             neg;
      logic             bad;
   } tok_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [VALUE_W-1:0] value;
      logic                      err;
   } res_type;

   function automatic logic is_ws(logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   // append one byte to the open token
   function automatic tok_type add_char(tok_type t, logic [7:0] b);
      tok_type r;
      r = t;
      if (t.len == '0 && b == CH_MINUS) begin
         r.neg = 1'b1;
      end else if (b >= CH_ZERO && b <= CH_NINE) begin
         if (32'(t.len) < MAX_INT_CHARS)
            r.acc = (t.acc << 3) + (t.acc << 1) + ACC_W'(b[3:0]);
      end else begin
         r.bad = 1'b1;
      end
      if (32'(t.len) < MAX_TOKEN_CHARS) r.len = t.len + 1'b1;
      return r;
   endfunction

   function automatic logic tok_full(tok_type t);
      return 32'(t.len) >= MAX_TOKEN_CHARS;
   endfunction

   // close the token: error or signed value, sticky error updated
   function automatic res_type finish_tok(tok_type t, logic st);
      res_type          r;
      logic             bad;
      logic [NEG_W-1:0] m;
      bad = t.bad || (32'(t.len) > MAX_INT_CHARS) ||
            (32'(t.len) >= MAX_TOKEN_CHARS) || st;
      m   = NEG_W'(t.acc);
      if (t.neg) m = -m;
      r.err   = st | bad;
      r.kind  = bad ? KIND_ERR : KIND_INT;
      r.value = bad ? '0 : m[VALUE_W-1:0];
      return r;
   endfunction

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // lexer state
   mode_type         mode_ff, mode_in;
   logic             ph_ff, ph_in;
   logic             sbar_ff, sbar_in;
   logic             shash_ff, shash_in;
   logic [DEP_W-1:0] depth_ff, depth_in;
   tok_type          tok_ff, tok_in;
   logic             sticky_ff, sticky_in;

   // result register
   logic                      out_vld_ff, out_vld_in;
   logic [1:0]                out_kind_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      out_err_ff;

   res_type    res_v;
   logic       res_vld;
   logic       do_tb;
   logic       do_ib;
   logic       advance;

   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign in_vld_in      = req_chan.valid ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in     = advance ? res_vld : (rsp_chan.ready ? 1'b0 : out_vld_ff);

   // lexer update for the registered byte
   always_comb begin
      mode_in   = mode_ff;
      ph_in     = ph_ff;
      sbar_in   = sbar_ff;
      shash_in  = shash_ff;
      depth_in  = depth_ff;
      tok_in    = tok_ff;
      sticky_in = sticky_ff;
      res_v     = '0;
      res_vld   = 1'b0;
      do_tb     = 1'b0;
      do_ib     = 1'b0;

      if (in_end_ff) begin
         // end of stream always yields one result
         res_vld = 1'b1;
         if (mode_ff == MODE_TOKEN || (mode_ff == MODE_IDLE && ph_ff)) begin
            if (mode_ff == MODE_IDLE) tok_in = '0;
            if (ph_ff) tok_in = add_char(tok_in, CH_HASH);
            res_v = finish_tok(tok_in, sticky_in);
         end else if (mode_ff == MODE_IDLE) begin
            res_v.kind = sticky_ff ? KIND_ERR : KIND_END;
            res_v.err  = sticky_ff;
         end else begin
            res_v.kind = KIND_ERR;
            res_v.err  = 1'b1;
         end
         sticky_in = res_v.err;
         mode_in   = MODE_IDLE;
         ph_in     = 1'b0;
         sbar_in   = 1'b0;
         shash_in  = 1'b0;
         depth_in  = '0;
         tok_in    = '0;
      end else begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (ph_ff) begin
                  ph_in = 1'b0;
                  if (in_byte_ff == CH_BAR) begin
                     mode_in  = MODE_BLOCK;
                     depth_in = '0;
                     sbar_in  = 1'b0;
                     shash_in = 1'b0;
                  end else begin
                     mode_in = MODE_TOKEN;
                     tok_in  = add_char('0, CH_HASH);
                     do_tb   = 1'b1;
                  end
               end else begin
                  do_ib = 1'b1;
               end
            end
            MODE_TOKEN: begin
               if (ph_ff) begin
                  ph_in = 1'b0;
                  if (in_byte_ff == CH_BAR) begin
                     res_v     = finish_tok(tok_ff, sticky_ff);
                     sticky_in = res_v.err;
                     res_vld   = 1'b1;
                     tok_in    = '0;
                     mode_in   = MODE_BLOCK;
                     depth_in  = '0;
                     sbar_in   = 1'b0;
                     shash_in  = 1'b0;
                  end else begin
                     tok_in = add_char(tok_ff, CH_HASH);
                     if (tok_full(tok_in)) begin
                        res_v     = finish_tok(tok_in, sticky_ff);
                        sticky_in = res_v.err;
                        res_vld   = 1'b1;
                        tok_in    = '0;
                        mode_in   = MODE_IDLE;
                        do_ib     = 1'b1;
                     end else begin
                        do_tb = 1'b1;
                     end
                  end
               end else begin
                  do_tb = 1'b1;
               end
            end
            MODE_LINE: begin
               if (in_byte_ff == CH_LF || in_byte_ff == CH_CR) mode_in = MODE_IDLE;
            end
            MODE_BLOCK: begin
               sbar_in  = (in_byte_ff == CH_BAR);
               shash_in = (in_byte_ff == CH_HASH);
               if (sbar_ff && in_byte_ff == CH_HASH) begin
                  // closing bar-hash
                  sbar_in  = 1'b0;
                  shash_in = 1'b0;
                  if (depth_ff != '0) depth_in = depth_ff - 1'b1;
                  else mode_in = MODE_IDLE;
               end else if (shash_ff && in_byte_ff == CH_BAR) begin
                  // nested opening, saturating with a sticky error
                  sbar_in  = 1'b0;
                  shash_in = 1'b0;
                  if (32'(depth_ff) < MAX_NESTING) depth_in = depth_ff + 1'b1;
                  else sticky_in = 1'b1;
               end
            end
         endcase
      end

      // byte inside an open token
      if (do_tb) begin
         if (is_ws(in_byte_ff) || in_byte_ff == CH_SEMI) begin
            res_v     = finish_tok(tok_in, sticky_in);
            sticky_in = res_v.err;
            res_vld   = 1'b1;
            tok_in    = '0;
            mode_in   = (in_byte_ff == CH_SEMI) ? MODE_LINE : MODE_IDLE;
         end else if (in_byte_ff == CH_HASH) begin
            ph_in = 1'b1;
         end else begin
            tok_in = add_char(tok_in, in_byte_ff);
            if (tok_full(tok_in)) begin
               res_v     = finish_tok(tok_in, sticky_in);
               sticky_in = res_v.err;
               res_vld   = 1'b1;
               tok_in    = '0;
               mode_in   = MODE_IDLE;
            end
         end
      end

      // byte while idle with no held hash
      if (do_ib && !is_ws(in_byte_ff)) begin
         if (in_byte_ff == CH_SEMI) begin
            mode_in = MODE_LINE;
         end else if (in_byte_ff == CH_HASH) begin
            ph_in = 1'b1;
         end else begin
            mode_in = MODE_TOKEN;
            tok_in  = add_char('0, in_byte_ff);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         mode_ff    <= MODE_IDLE;
         ph_ff      <= 1'b0;
         sbar_ff    <= 1'b0;
         shash_ff   <= 1'b0;
         depth_ff   <= '0;
         tok_ff     <= '0;
         sticky_ff  <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            mode_ff   <= mode_in;
            ph_ff     <= ph_in;
            sbar_ff   <= sbar_in;
            shash_ff  <= shash_in;
            depth_ff  <= depth_in;
            tok_ff    <= tok_in;
            sticky_ff <= sticky_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.stream_end;
      end
      if (advance && res_vld) begin
         out_kind_ff  <= res_v.kind;
         out_value_ff <= res_v.value;
         out_err_ff   <= res_v.err;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.token_kind  = out_kind_ff;
   assign rsp_chan.token_value = out_value_ff;
   assign rsp_chan.error_flag  = out_err_ff;

   // checks
   `NCIL_ASSERT_NEXT(a_sticky_holds, clock, reset, sticky_ff, sticky_ff,
                     "sticky error cleared")
   `NCIL_ASSERT_NOW(a_err_flagged, clock, reset,
                    out_vld_ff && out_kind_ff == KIND_ERR, out_err_ff,
                    "error result without error flag")
   `NCIL_ASSERT_NOW(a_value_zero, clock, reset,
                    out_vld_ff && out_kind_ff != KIND_INT, out_value_ff == '0,
                    "non-integer result with non-zero value")
   `NCIL_ASSERT_NOW(a_depth_idle, clock, reset, mode_ff != MODE_BLOCK, depth_ff == '0,
                    "nesting depth left non-zero outside block comment")

endmodule
`default_nettype wire
